/* hdl/mbrb_pkg.sv */
// ----------------------------------------------------------------------------
// mbrb_pkg
// shared types and codes for the message byte ring buffer
// ----------------------------------------------------------------------------
package mbrb_pkg;

	localparam int SAFETY_W = 6;
	localparam int COUNT_W  = 7;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
	localparam logic [SAFETY_W-1:0] SAFETY_RESET = 6'd16;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_BYTE   = 2'd1,
		KIND_EMPTY  = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		WS_ACCEPTED  = 2'd0,
		WS_REJECTED  = 2'd1,
		WS_TRUNCATED = 2'd2
	} write_status_t;

	typedef struct packed {
		result_kind_t  kind;
		write_status_t status;
		logic [7:0]    data;
		logic          last;
	} result_t;

endpackage

/* hdl/message_byte_ring_buffer.sv */
// ----------------------------------------------------------------------------
// message_byte_ring_buffer
// ring buffer of message bytes with admission check and burst drains
// ----------------------------------------------------------------------------
// Write beats are taken one per cycle; a message's last beat queues one status
// result. A drain beat queues a read-out of every unread byte, which then
// appear on the output one per cycle while the output is not stalled, limited
// by the single read port of the byte store; while a drain is still being
// read out, and while the command queue is full, the input is stalled.
// Results wait in a two-entry output buffer, so output stall does not stop
// write beats until the command queue fills. safety_len may be written only
// while the block is idle. No clearing pass after reset.
module message_byte_ring_buffer import mbrb_pkg::*; #(
	parameter int BUF_BYTES  = 64,
	parameter int CMDQ_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] data_byte,
	input  logic       first_of_message,
	input  logic       last_of_message,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output logic [1:0] write_status,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	input  logic       cfg_wr_en,
	input  logic [5:0] cfg_wr_data
);

	localparam int AW    = $clog2(BUF_BYTES);
	localparam int CMD_W = 2 * AW + 3;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [7:0]       mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [7:0]       mem_rdata;
	logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic [CMD_W-1:0] cmd_in, cmd_out;
	logic             drain_done;
	result_t          out_res;

	mbrb_front #(
		.BUF_BYTES(BUF_BYTES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.cmd_push         (cmd_push),
		.cmd_data         (cmd_in),
		.cmd_full         (cmd_full),
		.drain_done       (drain_done)
	);

	mbrb_cmd_queue #(
		.WIDTH(CMD_W),
		.DEPTH(CMDQ_DEPTH)
	) u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.pop_data  (cmd_out),
		.empty     (cmd_empty)
	);

	mbrb_ram #(
		.WIDTH(8),
		.DEPTH(BUF_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mbrb_back #(
		.BUF_BYTES(BUF_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (cmd_empty),
		.cmd_data   (cmd_out),
		.cmd_pop    (cmd_pop),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.drain_done (drain_done),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (out_res)
	);

	assign result_kind  = out_res.kind;
	assign write_status = out_res.status;
	assign out_byte     = out_res.data;
	assign last_of_run  = out_res.last;

endmodule

/* hdl/mbrb_ram.sv */
// ----------------------------------------------------------------------------
// mbrb_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mbrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/mbrb_cmd_queue.sv */
// ----------------------------------------------------------------------------
// mbrb_cmd_queue
// short fifo of commands between the front and the back
// ----------------------------------------------------------------------------
module mbrb_cmd_queue #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/mbrb_front.sv */
// ----------------------------------------------------------------------------
// mbrb_front
// accepts input beats, runs admission, writes message bytes, issues commands
// ----------------------------------------------------------------------------
module mbrb_front import mbrb_pkg::*; #(
	parameter int BUF_BYTES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [7:0]                   data_byte,
	input  logic                         first_of_message,
	input  logic                         last_of_message,
	input  logic                         cfg_wr_en,
	input  logic [SAFETY_W-1:0]          cfg_wr_data,
	output logic                         mem_we,
	output logic [$clog2(BUF_BYTES)-1:0] mem_waddr,
	output logic [7:0]                   mem_wdata,
	output logic                         cmd_push,
	output logic [2*$clog2(BUF_BYTES)+2:0] cmd_data,
	input  logic                         cmd_full,
	input  logic                         drain_done
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam int PW = AW + 1;
	localparam int CW = ((PW > SAFETY_W) ? PW : SAFETY_W) + 1;
	localparam logic [PW-1:0] BUF_P  = PW'(BUF_BYTES);
	localparam logic [CW-1:0] BUF_C  = CW'(BUF_BYTES);
	localparam logic [AW-1:0] TOP_SLOT = AW'(BUF_BYTES - 1);

	typedef struct packed {
		logic          is_drain;
		write_status_t status;
		logic [AW-1:0] count;
		logic [AW-1:0] start;
	} cmd_t;

	logic [SAFETY_W-1:0] safety_q;
	logic [AW-1:0]       rd_pos_q;
	logic [PW-1:0]       pub_pos_q, pend_pos_q;
	logic                rejected_q;
	logic [COUNT_W-1:0]  byte_cnt_q;
	logic                drain_busy_q;

	logic                accept;
	logic [CW-1:0]       w_c, r_c, len_c, to_end;
	logic                overwrite;
	logic                rej_eff;
	logic [PW-1:0]       pend_eff, pend_new;
	logic [COUNT_W-1:0]  cnt_eff, cnt_new;
	logic                store_byte;
	logic [AW-1:0]       wr_slot;
	write_status_t       msg_status;
	logic [PW-1:0]       pub_m1;
	logic [PW-1:0]       drain_cnt;
	logic [AW-1:0]       drain_start;
	cmd_t                cmd;

	assign in_stall = cmd_full || drain_busy_q;
	assign accept   = in_valid && !in_stall;

	// admission: sequential test or wrap-around test against the read position
	always_comb begin
		w_c       = CW'(pub_pos_q);
		r_c       = CW'(rd_pos_q);
		len_c     = CW'(safety_q);
		to_end    = BUF_C - w_c;
		overwrite = ((w_c < r_c) && (w_c + len_c >= r_c))
			|| ((len_c > to_end) && (len_c - to_end >= r_c));
	end

	always_comb begin
		rej_eff    = first_of_message ? overwrite : rejected_q;
		pend_eff   = first_of_message ? pub_pos_q : pend_pos_q;
		cnt_eff    = first_of_message ? '0 : byte_cnt_q;
		store_byte = !rej_eff && (cnt_eff < COUNT_W'(safety_q));
		wr_slot    = (pend_eff == BUF_P) ? '0 : pend_eff[AW-1:0];
		pend_new   = store_byte ? (PW'(wr_slot) + 1'b1) : pend_eff;
		cnt_new    = (!rej_eff && (cnt_eff != COUNT_MAX)) ? cnt_eff + 1'b1 : cnt_eff;
		if (rej_eff) begin
			msg_status = WS_REJECTED;
		end else if (cnt_new > COUNT_W'(safety_q)) begin
			msg_status = WS_TRUNCATED;
		end else begin
			msg_status = WS_ACCEPTED;
		end
	end

	// unread bytes lie between the read position and the published position
	always_comb begin
		pub_m1 = pub_pos_q - 1'b1;
		if (pub_m1 >= PW'(rd_pos_q)) begin
			drain_cnt = pub_m1 - PW'(rd_pos_q);
		end else begin
			drain_cnt = pub_m1 + BUF_P - PW'(rd_pos_q);
		end
		drain_start = (rd_pos_q == TOP_SLOT) ? '0 : rd_pos_q + 1'b1;
	end

	always_comb begin
		cmd.is_drain = operation;
		cmd.status   = operation ? WS_ACCEPTED : msg_status;
		cmd.count    = drain_cnt[AW-1:0];
		cmd.start    = drain_start;
	end

	assign cmd_push  = accept && (operation || last_of_message);
	assign cmd_data  = cmd;
	assign mem_we    = accept && !operation && store_byte;
	assign mem_waddr = wr_slot;
	assign mem_wdata = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safety_q     <= SAFETY_RESET;
			rd_pos_q     <= '0;
			pub_pos_q    <= PW'(1);
			pend_pos_q   <= PW'(1);
			rejected_q   <= 1'b0;
			byte_cnt_q   <= '0;
			drain_busy_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				safety_q <= cfg_wr_data;
			end
			if (drain_done) begin
				drain_busy_q <= 1'b0;
			end
			if (accept) begin
				if (operation) begin
					// read position lands on the last published byte
					rd_pos_q     <= pub_m1[AW-1:0];
					drain_busy_q <= 1'b1;
				end else if (last_of_message) begin
					if (!rej_eff) begin
						pub_pos_q  <= pend_new;
						pend_pos_q <= pend_new;
					end else begin
						pend_pos_q <= pub_pos_q;
					end
					rejected_q <= 1'b1;
					byte_cnt_q <= '0;
				end else begin
					rejected_q <= rej_eff;
					pend_pos_q <= pend_new;
					byte_cnt_q <= cnt_new;
				end
			end
		end
	end

endmodule

/* hdl/mbrb_back.sv */
// ----------------------------------------------------------------------------
// mbrb_back
// executes commands: status results and drains read out of the byte store
// ----------------------------------------------------------------------------
module mbrb_back import mbrb_pkg::*; #(
	parameter int BUF_BYTES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_empty,
	input  logic [2*$clog2(BUF_BYTES)+2:0] cmd_data,
	output logic                           cmd_pop,
	output logic                           mem_re,
	output logic [$clog2(BUF_BYTES)-1:0]   mem_raddr,
	input  logic [7:0]                     mem_rdata,
	output logic                           drain_done,
	output logic                           out_valid,
	input  logic                           out_stall,
	output result_t                        out_res
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam logic [AW-1:0] TOP_SLOT = AW'(BUF_BYTES - 1);

	typedef struct packed {
		logic          is_drain;
		write_status_t status;
		logic [AW-1:0] count;
		logic [AW-1:0] start;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'b01,
		BK_DRAIN = 2'b10
	} back_state_t;

	back_state_t state_q;
	logic [AW-1:0] slot_q, rem_q;

	logic    iss_valid_s1;
	result_t iss_res_s1;

	result_t  fifo_q [2];
	logic     fifo_wp_q, fifo_rp_q;
	logic [1:0] fifo_cnt_q;

	cmd_t    cmd;
	logic    pop_out;
	logic    issue_ok;
	logic    issue;
	result_t issue_res;
	logic    fifo_push;
	result_t fifo_in;

	assign cmd       = cmd_data;
	assign out_valid = (fifo_cnt_q != 2'd0);
	assign out_res   = fifo_q[fifo_rp_q];
	assign pop_out   = out_valid && !out_stall;

	// room for one more result counting the one in flight through the ram
	always_comb begin
		issue_ok = ((fifo_cnt_q + 2'(iss_valid_s1)) < (pop_out ? 2'd3 : 2'd2));
	end

	always_comb begin
		issue             = 1'b0;
		cmd_pop           = 1'b0;
		mem_re            = 1'b0;
		mem_raddr         = slot_q;
		drain_done        = 1'b0;
		issue_res.kind    = KIND_BYTE;
		issue_res.status  = WS_ACCEPTED;
		issue_res.data    = '0;
		issue_res.last    = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (!cmd_empty && issue_ok) begin
					issue   = 1'b1;
					cmd_pop = 1'b1;
					if (!cmd.is_drain) begin
						issue_res.kind   = KIND_STATUS;
						issue_res.status = cmd.status;
					end else if (cmd.count == '0) begin
						issue_res.kind = KIND_EMPTY;
						drain_done     = 1'b1;
					end else begin
						mem_re         = 1'b1;
						mem_raddr      = cmd.start;
						issue_res.last = (cmd.count == AW'(1));
						drain_done     = (cmd.count == AW'(1));
					end
				end
			end
			BK_DRAIN: begin
				if (issue_ok) begin
					issue          = 1'b1;
					mem_re         = 1'b1;
					issue_res.last = (rem_q == AW'(1));
					drain_done     = (rem_q == AW'(1));
				end
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			iss_valid_s1 <= 1'b0;
		end else begin
			iss_valid_s1 <= issue;
			case (state_q)
				BK_IDLE: begin
					if (issue && cmd.is_drain && (cmd.count > AW'(1))) begin
						state_q <= BK_DRAIN;
					end
				end
				BK_DRAIN: begin
					if (issue && (rem_q == AW'(1))) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			iss_res_s1 <= issue_res;
			if (state_q == BK_IDLE) begin
				slot_q <= (cmd.start == TOP_SLOT) ? '0 : cmd.start + 1'b1;
				rem_q  <= cmd.count - 1'b1;
			end else begin
				slot_q <= (slot_q == TOP_SLOT) ? '0 : slot_q + 1'b1;
				rem_q  <= rem_q - 1'b1;
			end
		end
	end

	// drained bytes take their value from the registered ram read
	always_comb begin
		fifo_push = iss_valid_s1;
		fifo_in   = iss_res_s1;
		if (iss_res_s1.kind == KIND_BYTE) begin
			fifo_in.data = mem_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_push) begin
			fifo_q[fifo_wp_q] <= fifo_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_wp_q  <= 1'b0;
			fifo_rp_q  <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (fifo_push) begin
				fifo_wp_q <= !fifo_wp_q;
			end
			if (pop_out) begin
				fifo_rp_q <= !fifo_rp_q;
			end
			if (fifo_push && !pop_out) begin
				fifo_cnt_q <= fifo_cnt_q + 2'd1;
			end else if (pop_out && !fifo_push) begin
				fifo_cnt_q <= fifo_cnt_q - 2'd1;
			end
		end
	end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Tests the message byte ring buffer: whole messages go in as write beats,
// drains come back as bursts of bytes. A shadow copy of the ring and of the
// admission logic predicts every result, and each output beat is compared
// field by field with the oldest prediction. Idling is varied on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import mbrb_pkg::*;

	localparam int BUF_BYTES = 64;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAIN = 1'b1;
	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT = 4000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       operation = OP_WRITE;
	logic [7:0] data_byte = 8'd0;
	logic       first_of_message = 1'b0;
	logic       last_of_message = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] result_kind;
	logic [1:0] write_status;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       cfg_wr_en = 1'b0;
	logic [5:0] cfg_wr_data = 6'd0;

	int send_idle_pct = 8;
	int recv_stall_pct = 57;
	int errors = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int messages_sent = 0;
	int drains_sent = 0;
	int quiet_cycles = 0;

	// results still owed by the ring, oldest first
	result_t ring_results_due[$];

	// shadow of the ring state
	logic [7:0]           shadow_store [BUF_BYTES];
	logic [BUF_BYTES-1:0] shadow_written = '0;
	logic [6:0]           shadow_rd = 7'd0;
	logic [6:0]           shadow_pub = 7'd1;
	logic [6:0]           shadow_pend = 7'd1;
	logic [6:0]           shadow_count = 7'd0;
	logic                 shadow_rejected = 1'b0;
	logic [5:0]           shadow_safety = SAFETY_RESET;

	message_byte_ring_buffer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.write_status     (write_status),
		.out_byte         (out_byte),
		.last_of_run      (last_of_run),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic bit ring_would_overrun();
		int w;
		int r;
		int len;
		int to_end;
		bit seq_hit;
		bit wrap_hit;
		w = int'(shadow_pub);
		r = int'(shadow_rd);
		len = int'(shadow_safety);
		to_end = (w <= BUF_BYTES) ? BUF_BYTES - w : 0;
		seq_hit = (w < r) && (w + len >= r);
		wrap_hit = (len > to_end) && (len - to_end >= r);
		return seq_hit || wrap_hit;
	endfunction

	function automatic int unread_bytes();
		return (shadow_pub + BUF_BYTES - shadow_rd - 1) % BUF_BYTES;
	endfunction

	// a drain must never touch a slot that no admitted message wrote
	function automatic bit drain_reads_written();
		int slot;
		int n;
		n = unread_bytes();
		slot = (shadow_rd + 1) % BUF_BYTES;
		for (int i = 0; i < n; i++) begin
			if (!shadow_written[slot])
				return 1'b0;
			slot = (slot + 1) % BUF_BYTES;
		end
		return 1'b1;
	endfunction

	task automatic predict_ring_results(input logic op, input logic [7:0] data,
			input logic first, input logic last);
		int n;
		int slot;
		result_t r;
		r.kind = KIND_STATUS;
		r.status = WS_ACCEPTED;
		r.data = 8'd0;
		r.last = 1'b1;
		if (op == OP_DRAIN) begin
			n = unread_bytes();
			if (n == 0) begin
				r.kind = KIND_EMPTY;
				ring_results_due.push_back(r);
				return;
			end
			slot = (shadow_rd + 1) % BUF_BYTES;
			for (int i = 0; i < n; i++) begin
				r.kind = KIND_BYTE;
				r.data = shadow_store[slot];
				r.last = (i == n - 1);
				ring_results_due.push_back(r);
				slot = (slot + 1) % BUF_BYTES;
			end
			shadow_rd = 7'((shadow_rd + n) % BUF_BYTES);
			return;
		end
		if (first) begin
			shadow_rejected = ring_would_overrun();
			shadow_pend = shadow_pub;
			shadow_count = 7'd0;
		end
		if (!shadow_rejected) begin
			if (shadow_count < shadow_safety) begin
				slot = shadow_pend % BUF_BYTES;
				shadow_store[slot] = data;
				shadow_written[slot] = 1'b1;
				shadow_pend = 7'(slot + 1);
			end
			if (shadow_count < COUNT_MAX)
				shadow_count = shadow_count + 7'd1;
		end
		if (!last)
			return;
		if (shadow_rejected) begin
			r.status = WS_REJECTED;
		end else begin
			r.status = (shadow_count > shadow_safety) ? WS_TRUNCATED : WS_ACCEPTED;
			shadow_pub = shadow_pend;
		end
		ring_results_due.push_back(r);
		shadow_rejected = 1'b1;
		shadow_count = 7'd0;
		shadow_pend = shadow_pub;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (ring_results_due.size() == 0) begin
				report_mismatch("result beat with nothing owed, kind", result_kind, -1);
			end else begin
				want = ring_results_due.pop_front();
				if (result_kind !== want.kind)
					report_mismatch("result_kind", result_kind, want.kind);
				if (write_status !== want.status)
					report_mismatch("write_status", write_status, want.status);
				if (out_byte !== want.data)
					report_mismatch("out_byte", out_byte, want.data);
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", last_of_run, want.last);
			end
		end
	end

	// ends the run when neither side has moved a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d results still owed",
				QUIET_LIMIT, ring_results_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_beat(input logic op, input logic [7:0] data,
			input logic first, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= data;
		first_of_message <= first;
		last_of_message <= last;
		do @(posedge clk); while (in_stall);
		predict_ring_results(op, data, first, last);
		beats_sent++;
	endtask

	task automatic hold_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		hold_input();
		while (ring_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_safety(input logic [5:0] value);
		wait_results_drained();
		// non-last beats owe no result and push no command into the command queue
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		shadow_safety = value;
	endtask

	task automatic send_drain();
		if (drain_reads_written()) begin
			// payload fields are don't-care on a drain, so toggle them anyway
			send_beat(OP_DRAIN, 8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
			drains_sent++;
		end
	endtask

	task automatic send_message(input int len, input bit mid_drains);
		for (int i = 0; i < len; i++) begin
			send_beat(OP_WRITE, 8'($urandom_range(255)), i == 0, i == len - 1);
			if (mid_drains && i < len - 1 && $urandom_range(99) < 8)
				send_drain();
		end
		messages_sent++;
	endtask

	task automatic test_reset_corners();
		send_drain();
		// stray beats right after reset extend an admitted empty message
		send_beat(OP_WRITE, 8'h00, 1'b0, 1'b0);
		send_beat(OP_WRITE, 8'hFF, 1'b0, 1'b1);
		send_drain();
		send_drain();
	endtask

	task automatic test_message_shapes();
		send_beat(OP_WRITE, 8'hA5, 1'b1, 1'b1);
		send_beat(OP_WRITE, 8'h5A, 1'b1, 1'b0);
		// drain in the middle of a message sees only published bytes
		send_drain();
		send_beat(OP_WRITE, 8'h3C, 1'b0, 1'b1);
		send_drain();
		send_beat(OP_WRITE, 8'h11, 1'b0, 1'b1);
		send_beat(OP_WRITE, 8'h22, 1'b0, 1'b0);
		// restart before the last beat abandons the open message
		send_beat(OP_WRITE, 8'h01, 1'b1, 1'b0);
		send_beat(OP_WRITE, 8'h02, 1'b1, 1'b1);
		send_drain();
	endtask

	task automatic test_safety_extremes();
		write_safety(6'd1);
		send_beat(OP_WRITE, 8'h80, 1'b1, 1'b0);
		send_beat(OP_WRITE, 8'h40, 1'b0, 1'b0);
		send_beat(OP_WRITE, 8'hC0, 1'b0, 1'b1);
		send_drain();
		write_safety(6'd0);
		send_beat(OP_WRITE, 8'h7F, 1'b1, 1'b1);
		send_drain();
		write_safety(6'd63);
		send_beat(OP_WRITE, 8'hF0, 1'b1, 1'b1);
		send_beat(OP_WRITE, 8'h0F, 1'b1, 1'b1);
		send_drain();
	endtask

	task automatic test_count_saturation();
		write_safety(6'd2);
		send_message(130, 1'b0);
		send_drain();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input logic [5:0] safety, input int beats);
		int stop_at;
		int pick;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		write_safety(safety);
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_message($urandom_range(shadow_safety + 2, 1), 1'b1);
			end else if (pick < 75) begin
				send_drain();
			end else if (pick < 85) begin
				repeat ($urandom_range(3, 1))
					send_beat(OP_WRITE, 8'($urandom_range(255)), 1'b0,
						1'($urandom_range(1)));
			end else if (pick < 93) begin
				send_beat(OP_WRITE, 8'($urandom_range(255)), 1'b1, 1'b0);
				repeat ($urandom_range(3))
					send_beat(OP_WRITE, 8'($urandom_range(255)), 1'b0, 1'b0);
			end else begin
				send_beat(OP_WRITE, 8'($urandom_range(255)), 1'b1, 1'b1);
				messages_sent++;
			end
			if ($urandom_range(99) < 3)
				wait_results_drained();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_corners();
		test_message_shapes();
		test_safety_extremes();
		test_count_saturation();
		test_random_traffic(8, 57, 6'($urandom_range(20, 4)), 25);
		test_random_traffic(57, 8, 6'($urandom_range(63, 1)), 25);
		test_random_traffic(0, 0, 6'd8, 25);
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d input beats (%0d messages, %0d drains), %0d result beats",
			beats_sent, messages_sent, drains_sent, results_seen);
		$display("safety_len 16, 1, 0, 63, 2 and three random settings, idling on both sides");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
